[rtl/smvm_pkg.sv]
package smvm_pkg;

  // Defaults for the top-level parameters
  localparam int VECTOR_DEPTH_DEF = 1024;
  localparam int MAX_ROWS_DEF     = 65536;

  // Field widths
  localparam int FUNC_W   = 2;
  localparam int COL_W    = 10;
  localparam int OPND_W   = 16;
  localparam int PROD_W   = 2 * OPND_W;
  localparam int SUM_W    = 48;
  localparam int ROW_W    = 16;
  localparam int NCOLS_W  = 11;
  localparam int NROWS_W  = 17;

  // Bus widths
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 64;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;

  // Input word layout
  localparam int FUNC_LSB = 0;
  localparam int COL_LSB  = FUNC_LSB + FUNC_W;
  localparam int OPND_LSB = COL_LSB + COL_W;

  // Function codes
  localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ENTRY = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_EMPTY = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 1'd1;

  // Register reset values
  localparam logic [NCOLS_W-1:0] NUM_COLS_RST = 11'd1024;
  localparam logic [NROWS_W-1:0] NUM_ROWS_RST = 17'd65536;

endpackage

[rtl/smvm_ram.sv]
module smvm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/sparse_matrix_vector_multiply_top.sv]
// Channel   Dir  Word fields (low bit up)                        Handshake
// s_*       in   tdata: func[1:0] column[11:2] operand[27:12]    s_tvalid / s_tready
//                tlast: last_in_row
// m_*       out  tdata: row_sum[47:0] row_number[63:48]          m_tvalid / m_tready
//                tlast: last_row, tuser: range_error
// cfg_*     in   index 0 num_cols, index 1 num_rows              cfg_valid / cfg_ready
//
// One input word per cycle, sustained until a stalled output fills the pipeline.
// A row result passes the vector store read, the multiply and the accumulate into
// the output register that drives m_tvalid, after the word that ends the row.
// The vector store is one memory with one write and one registered read port;
// loads write it, matrix entries read it, one access per word.
// Synchronous reset clears the pipeline valids, accumulator, row counter and
// registers; the vector store is not cleared, so no clearing pass is needed.
// Each stage advances when the one after it is empty or moving, so bubbles
// absorb a stalled output before s_tready drops.
module sparse_matrix_vector_multiply_top #(
  parameter int VECTOR_DEPTH = smvm_pkg::VECTOR_DEPTH_DEF,
  parameter int MAX_ROWS     = smvm_pkg::MAX_ROWS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // input word: func[1:0], column[11:2], operand[27:12], zero pad [31:28]
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [smvm_pkg::IN_DATA_W-1:0]   s_tdata,
  input  logic                             s_tlast,
  // result word: row_sum[47:0], row_number[63:48]
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [smvm_pkg::OUT_DATA_W-1:0]  m_tdata,
  output logic                             m_tlast,
  // result flag: range_error[0]
  output logic                             m_tuser,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [smvm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [smvm_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import smvm_pkg::*;

  localparam int ADDR_W = $clog2(VECTOR_DEPTH);
  localparam logic [NROWS_W-1:0] DEPTH_LIM = NROWS_W'(VECTOR_DEPTH);
  localparam logic [NROWS_W-1:0] ROWS_CAP  = NROWS_W'(MAX_ROWS);

  // Configuration registers
  logic [NCOLS_W-1:0] num_cols;
  logic [NROWS_W-1:0] num_rows;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_cols <= NUM_COLS_RST;
      num_rows <= NUM_ROWS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_NUM_COLS: num_cols <= cfg_data[NCOLS_W-1:0];
        REG_NUM_ROWS: num_rows <= cfg_data[NROWS_W-1:0];
        default: ;
      endcase
    end
  end

  // Input word decode
  logic [FUNC_W-1:0]  in_func;
  logic [COL_W-1:0]   in_col;
  logic [OPND_W-1:0]  in_opnd;
  logic [NROWS_W-1:0] col_ext;
  logic               in_accept;
  logic               col_in_store;
  logic               col_ok;
  logic               is_row_word;

  assign in_func      = s_tdata[FUNC_LSB +: FUNC_W];
  assign in_col       = s_tdata[COL_LSB +: COL_W];
  assign in_opnd      = s_tdata[OPND_LSB +: OPND_W];
  assign col_ext      = NROWS_W'(in_col);
  assign in_accept    = s_tvalid && s_tready;
  assign col_in_store = col_ext < DEPTH_LIM;
  assign col_ok       = col_in_store && ({1'b0, in_col} < num_cols);
  assign is_row_word  = (in_func == FUNC_ENTRY) || (in_func == FUNC_EMPTY);

  // Vector store: loads write, entries read. A load and a later entry to the
  // same column fall on different edges, so the read sees the new value.
  logic              ram_wr_en;
  logic              ram_rd_en;
  logic [ADDR_W-1:0] ram_addr;
  logic [OPND_W-1:0] ram_rdata;

  assign ram_addr  = col_ext[ADDR_W-1:0];
  assign ram_wr_en = in_accept && (in_func == FUNC_LOAD) && col_in_store;
  assign ram_rd_en = in_accept && (in_func == FUNC_ENTRY) && col_ok;

  smvm_ram #(
    .WIDTH (OPND_W),
    .DEPTH (VECTOR_DEPTH)
  ) u_vec_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_addr),
    .wr_data (in_opnd),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_addr),
    .rd_data (ram_rdata)
  );

  // Stage 1: store read in flight
  logic              r_valid;
  logic              r_add;
  logic              r_err;
  logic              r_end;
  logic [OPND_W-1:0] r_weight;

  // Stage 2: product
  logic              p_valid;
  logic [PROD_W-1:0] p_prod;
  logic              p_err;
  logic              p_end;

  // Output register
  logic              out_valid;
  logic [SUM_W-1:0]  out_sum;
  logic [ROW_W-1:0]  out_row;
  logic              out_last;
  logic              out_err;

  // Row state
  logic [SUM_W-1:0]  acc;
  logic              row_err;
  logic [ROW_W-1:0]  row_counter;

  logic out_free;
  logic p_go;
  logic p_free;
  logic r_free;

  assign out_free = !out_valid || m_tready;
  assign p_go     = p_valid && (!p_end || out_free);
  assign p_free   = !p_valid || p_go;
  assign r_free   = !r_valid || p_free;
  assign s_tready = r_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (r_free) begin
      r_valid <= in_accept && is_row_word;
    end
  end

  always_ff @(posedge clk) begin
    if (r_free) begin
      r_add    <= (in_func == FUNC_ENTRY) && col_ok;
      r_err    <= (in_func == FUNC_ENTRY) && !col_ok;
      r_end    <= ((in_func == FUNC_ENTRY) && s_tlast) || (in_func == FUNC_EMPTY);
      r_weight <= in_opnd;
    end
  end

  logic signed [PROD_W-1:0] prod;
  assign prod = $signed(r_weight) * $signed(ram_rdata);

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (p_free) begin
      p_valid <= r_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (p_free) begin
      p_prod <= r_add ? prod : '0;
      p_err  <= r_err;
      p_end  <= r_end;
    end
  end

  // Accumulate and close rows
  logic [NROWS_W-1:0] rows_eff;
  logic [NROWS_W-1:0] cnt_inc;
  logic [SUM_W-1:0]   sum;
  logic               err_all;

  assign rows_eff = ((num_rows == '0) || (num_rows > ROWS_CAP)) ? ROWS_CAP : num_rows;
  assign cnt_inc  = NROWS_W'(row_counter) + NROWS_W'(1);
  assign sum      = acc + {{(SUM_W - PROD_W){p_prod[PROD_W-1]}}, p_prod};
  assign err_all  = row_err || p_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc         <= '0;
      row_err     <= 1'b0;
      row_counter <= '0;
    end else if (p_go) begin
      if (p_end) begin
        acc         <= '0;
        row_err     <= 1'b0;
        row_counter <= (cnt_inc >= rows_eff) ? '0 : cnt_inc[ROW_W-1:0];
      end else begin
        acc     <= sum;
        row_err <= err_all;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (p_go && p_end) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p_go && p_end) begin
      out_sum  <= sum;
      out_row  <= row_counter;
      out_last <= cnt_inc == rows_eff;
      out_err  <= err_all;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_row, out_sum};
  assign m_tlast  = out_last;
  assign m_tuser  = out_err;

  // A closing word always lands in the output register
  a_row_emits: assert property (@(posedge clk) disable iff (rst)
    p_go && p_end |=> m_tvalid)
    else $error("closed row did not reach the output register");

  // Accumulator restarts from zero after each row
  a_acc_clear: assert property (@(posedge clk) disable iff (rst)
    p_go && p_end |=> acc == '0 && !row_err)
    else $error("row state not cleared after row end");

  // Input backpressure only when both pipeline stages are occupied, the product stage ends a row and the output is full
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> r_valid && p_valid && p_end && out_valid)
    else $error("input stalled with room in the pipeline");

  // A held read stage keeps its store data
  a_rd_hold: assert property (@(posedge clk) disable iff (rst)
    r_valid && !p_free |=> r_valid && $stable(ram_rdata))
    else $error("store read data lost during stall");

endmodule

[sim/sparse_matrix_vector_multiply_top_tb.sv]
module sparse_matrix_vector_multiply_top_tb;
  import smvm_pkg::*;

  // func value 3 has no meaning; the block must drop such a word
  localparam logic [FUNC_W-1:0] FUNC_RESERVED = 2'd3;

  localparam int SETTLE_CYCLES = 8;     // pipeline is three deep, leave margin
  localparam int IDLE_LIMIT    = 2000;  // cycles with no handshake at all
  localparam int LONG_ROW_LEN  = 64;    // products of 2^30 in one row
  localparam int RANDOM_WORDS  = 80;    // per random phase

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [ROW_W-1:0] row;
    logic             last_row;
    logic             range_err;
  } row_result_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;   // func[1:0], column[11:2], operand[27:12], pad[31:28]
  logic                  s_tlast;   // last_in_row
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;   // row_sum[47:0], row_number[63:48]
  logic                  m_tlast;   // last_row
  logic                  m_tuser;   // range_error
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  sparse_matrix_vector_multiply_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Mirror of the block state, updated at every accepted word
  // ---------------------------------------------------------------------------
  logic [OPND_W-1:0]  vec_mirror  [VECTOR_DEPTH_DEF];
  bit                 vec_written [VECTOR_DEPTH_DEF];  // entries loaded since reset
  logic [SUM_W-1:0]   acc_mirror        = '0;
  int unsigned        row_idx_mirror    = 0;
  bit                 range_flag_mirror = 1'b0;
  logic [NCOLS_W-1:0] cols_setting      = NUM_COLS_RST;
  logic [NROWS_W-1:0] rows_setting      = NUM_ROWS_RST;

  row_result_t pending_rows [$];  // finished rows not yet seen on the output
  row_result_t want_row;

  int  fail_count  = 0;
  int  words_sent  = 0;
  int  idle_cycles = 0;
  bit  gaps_on     = 1'b1;
  bit  stalls_on   = 1'b1;

  // zero or out-of-range row count behaves as the full MAX_ROWS
  function automatic int unsigned eff_rows();
    if (rows_setting == 0 || rows_setting > MAX_ROWS_DEF) return MAX_ROWS_DEF;
    return rows_setting;
  endfunction

  // mostly no gap; when there is one, mostly short, now and then long
  function automatic int pick_gap(input int pct);
    int r;
    if ($urandom_range(0, 99) >= pct) return 0;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [OPND_W-1:0] pick_operand();
    case ($urandom_range(0, 19))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'hFFFF;
      3:       return 16'h0001;
      default: return OPND_W'($urandom);
    endcase
  endfunction

  // mostly valid columns; one in ten beyond num_cols when there is room
  function automatic int pick_column();
    if (cols_setting < VECTOR_DEPTH_DEF && $urandom_range(0, 9) == 0)
      return $urandom_range(cols_setting, VECTOR_DEPTH_DEF - 1);
    return $urandom_range(0, cols_setting - 1);
  endfunction

  task automatic close_row();
    row_result_t r;
    int unsigned rows;
    rows        = eff_rows();
    r.sum       = acc_mirror;
    r.row       = row_idx_mirror[ROW_W-1:0];
    r.last_row  = (row_idx_mirror + 1 == rows);
    r.range_err = range_flag_mirror;
    pending_rows.push_back(r);
    acc_mirror        = '0;
    range_flag_mirror = 1'b0;
    row_idx_mirror    = (row_idx_mirror + 1 >= rows) ? 0 : row_idx_mirror + 1;
  endtask

  // dot-product predictor: one call per accepted input word
  task automatic predict_row_sum(input logic [FUNC_W-1:0] fn, input logic [COL_W-1:0] col,
                                 input logic [OPND_W-1:0] opnd, input logic last);
    logic signed [PROD_W-1:0] prod;
    case (fn)
      FUNC_LOAD: begin
        vec_mirror[col]  = opnd;
        vec_written[col] = 1'b1;
      end
      FUNC_ENTRY: begin
        if (col < cols_setting) begin
          prod       = $signed(opnd) * $signed(vec_mirror[col]);
          acc_mirror = acc_mirror + {{(SUM_W-PROD_W){prod[PROD_W-1]}}, prod};
        end else begin
          range_flag_mirror = 1'b1;
        end
        if (last) close_row();
      end
      FUNC_EMPTY: close_row();
      default: ;  // reserved code: no effect
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Input side: one word per call (a load may go first), random gap in front of it
  // ---------------------------------------------------------------------------
  task automatic send_word(input logic [FUNC_W-1:0] fn, input logic [COL_W-1:0] col,
                           input logic [OPND_W-1:0] opnd, input logic last);
    int gap;
    // never read a vector element that was not loaded: load it first
    if (fn == FUNC_ENTRY && col < cols_setting && !vec_written[col])
      send_word(FUNC_LOAD, col, pick_operand(), 1'b0);
    gap = gaps_on ? pick_gap(30) : 0;
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_DATA_W-OPND_LSB-OPND_W){1'b0}}, opnd, col, fn};
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    predict_row_sum(fn, col, opnd, last);
    words_sent++;
  endtask

  // stop sending, wait for every pending row, then let the pipeline drain
  task automatic wait_rows_done();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_setting(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] val);
    wait_rows_done();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_NUM_COLS) cols_setting = val[NCOLS_W-1:0];
    else rows_setting = val[NROWS_W-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // extremes of the element value; tlast on a load must be ignored
  task automatic test_vector_load();
    send_word(FUNC_LOAD, 10'd0,    16'h8000, 1'b1);
    send_word(FUNC_LOAD, 10'd1023, 16'h7FFF, 1'b0);
    send_word(FUNC_LOAD, 10'd1,    16'h0001, 1'b0);
    send_word(FUNC_LOAD, 10'd2,    16'hFFFF, 1'b1);
    send_word(FUNC_LOAD, 10'd512,  16'h0100, 1'b0);
  endtask

  // largest positive product and some negative ones, in one- and two-entry rows
  task automatic test_entry_extremes();
    send_word(FUNC_ENTRY, 10'd0,    16'h8000, 1'b0);
    send_word(FUNC_ENTRY, 10'd1023, 16'h7FFF, 1'b1);
    send_word(FUNC_ENTRY, 10'd2,    16'h8000, 1'b1);
    send_word(FUNC_ENTRY, 10'd512,  16'hFFFF, 1'b0);
    send_word(FUNC_ENTRY, 10'd1,    16'h8000, 1'b1);
  endtask

  // a proper empty row, then an empty-row word that cuts an open row short
  task automatic test_empty_rows();
    send_word(FUNC_EMPTY, 10'h3FF, 16'hFFFF, 1'b1);
    send_word(FUNC_ENTRY, 10'd1,   16'h7FFF, 1'b0);
    send_word(FUNC_EMPTY, 10'd0,   16'h0000, 1'b0);
  endtask

  task automatic test_reserved_func();
    send_word(FUNC_RESERVED, 10'h3FF, 16'hFFFF, 1'b1);
    send_word(FUNC_RESERVED, 10'd0,   16'h0000, 1'b0);
    send_word(FUNC_EMPTY,    10'd0,   16'h0000, 1'b0);
  endtask

  // smallest column count: anything but column 0 flags the row
  task automatic test_column_range();
    write_setting(REG_NUM_COLS, CFG_DATA_W'(1));
    send_word(FUNC_ENTRY, 10'd0,   16'h0100, 1'b0);
    send_word(FUNC_ENTRY, 10'd1,   16'h7FFF, 1'b0);
    send_word(FUNC_ENTRY, 10'h3FF, 16'h8000, 1'b1);
    send_word(FUNC_EMPTY, 10'd0,   16'h0000, 1'b0);  // flag must be cleared
    write_setting(REG_NUM_COLS, CFG_DATA_W'(VECTOR_DEPTH_DEF));
    send_word(FUNC_ENTRY, 10'd1023, 16'h0100, 1'b1);
  endtask

  // row counter wrap, plus zero and oversized row counts acting as the maximum
  task automatic test_row_count();
    write_setting(REG_NUM_ROWS, CFG_DATA_W'(1));
    repeat (2) send_word(FUNC_EMPTY, 10'd0, 16'h0000, 1'b0);
    write_setting(REG_NUM_ROWS, CFG_DATA_W'(3));
    repeat (3) send_word(FUNC_EMPTY, 10'd0, 16'h0000, 1'b0);
    write_setting(REG_NUM_ROWS, CFG_DATA_W'(0));
    send_word(FUNC_EMPTY, 10'd0, 16'h0000, 1'b0);
    write_setting(REG_NUM_ROWS, 17'h1FFFF);
    send_word(FUNC_EMPTY, 10'd0, 16'h0000, 1'b0);
    write_setting(REG_NUM_ROWS, CFG_DATA_W'(MAX_ROWS_DEF));
  endtask

  // one long row of the largest product, words back to back
  task automatic test_long_row();
    int i;
    gaps_on = 1'b0;
    send_word(FUNC_LOAD, 10'd0, 16'h8000, 1'b0);
    for (i = 0; i < LONG_ROW_LEN; i++)
      send_word(FUNC_ENTRY, 10'd0, 16'h8000, i == LONG_ROW_LEN - 1);
    gaps_on = 1'b1;
  endtask

  // mostly well-formed rows with random content, some noise and broken rows
  task automatic test_random_rows();
    int phase, start, len, k, r;
    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          write_setting(REG_NUM_COLS, CFG_DATA_W'(VECTOR_DEPTH_DEF));
          write_setting(REG_NUM_ROWS, CFG_DATA_W'($urandom_range(1, 8)));
        end
        1: begin
          write_setting(REG_NUM_COLS, CFG_DATA_W'($urandom_range(1, 64)));
          write_setting(REG_NUM_ROWS, CFG_DATA_W'($urandom_range(1, MAX_ROWS_DEF)));
        end
        2: begin
          write_setting(REG_NUM_COLS, CFG_DATA_W'(1));
          write_setting(REG_NUM_ROWS, CFG_DATA_W'(2));
        end
        3: begin
          write_setting(REG_NUM_COLS, CFG_DATA_W'($urandom_range(1, VECTOR_DEPTH_DEF)));
          write_setting(REG_NUM_ROWS, CFG_DATA_W'($urandom_range(MAX_ROWS_DEF + 1, 17'h1FFFF)));
        end
        default: begin
          write_setting(REG_NUM_COLS, CFG_DATA_W'($urandom_range(1, 16)));
          write_setting(REG_NUM_ROWS, CFG_DATA_W'(MAX_ROWS_DEF));
        end
      endcase
      start = words_sent;
      while (words_sent - start < RANDOM_WORDS) begin
        // switch idling on and off now and then so some stretches run flat out
        if ($urandom_range(0, 19) == 0) gaps_on   = !gaps_on;
        if ($urandom_range(0, 19) == 0) stalls_on = !stalls_on;
        r = $urandom_range(0, 99);
        if (r < 10) begin
          send_word(FUNC_LOAD, COL_W'($urandom), pick_operand(), 1'($urandom));
        end else if (r < 13) begin
          send_word(FUNC_RESERVED, COL_W'($urandom), OPND_W'($urandom), 1'($urandom));
        end else if (r < 15) begin
          wait_rows_done();
        end else begin
          len = $urandom_range(0, 6);
          if (len == 0)
            send_word(FUNC_EMPTY, COL_W'($urandom), OPND_W'($urandom), 1'($urandom));
          for (k = 0; k < len; k++) begin
            if ($urandom_range(0, 24) == 0) begin
              // row cut short by an empty-row word
              send_word(FUNC_EMPTY, COL_W'($urandom), OPND_W'($urandom), 1'($urandom));
              break;
            end
            // the odd row misses its last flag and runs into the next one
            send_word(FUNC_ENTRY, COL_W'(pick_column()), pick_operand(),
                      (k == len - 1) && ($urandom_range(0, 15) != 0));
          end
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Clock, reset and sequence
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tlast   = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_vector_load();
    test_entry_extremes();
    test_empty_rows();
    test_reserved_func();
    test_column_range();
    test_row_count();
    test_long_row();
    test_random_rows();

    wait_rows_done();
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // output side: ready drops for random stretches
  initial begin
    int hold;
    hold     = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        m_tready <= 1'b0;
        hold--;
      end else begin
        m_tready <= 1'b1;
        if (stalls_on) hold = pick_gap(20);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result check: each output word against the oldest finished row
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_rows.size() == 0) begin
        $error("result word with no row pending: tdata=%h", m_tdata);
        fail_count++;
      end else begin
        want_row = pending_rows.pop_front();
        if (m_tdata[SUM_W-1:0] !== want_row.sum) begin
          $error("row_sum: expected %0d, got %0d",
                 $signed(want_row.sum), $signed(m_tdata[SUM_W-1:0]));
          fail_count++;
        end
        if (m_tdata[SUM_W+ROW_W-1:SUM_W] !== want_row.row) begin
          $error("row_number: expected %0d, got %0d",
                 want_row.row, m_tdata[SUM_W+ROW_W-1:SUM_W]);
          fail_count++;
        end
        if (m_tlast !== want_row.last_row) begin
          $error("last_row: expected %0b, got %0b", want_row.last_row, m_tlast);
          fail_count++;
        end
        if (m_tuser !== want_row.range_err) begin
          $error("range_error: expected %0b, got %0b", want_row.range_err, m_tuser);
          fail_count++;
        end
      end
    end
  end

  // watchdog: too long without any handshake means the block hung
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

endmodule

[sim.f]
rtl/smvm_pkg.sv
rtl/smvm_ram.sv
rtl/sparse_matrix_vector_multiply_top.sv
sim/sparse_matrix_vector_multiply_top_tb.sv
